### design/robb_pkg.sv
// Shared types and constants for the ray against oriented box slab test.
package robb_pkg;

  // Sequencer states of the per-axis evaluation.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_REDUCE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_FINISH
  } robb_state_e;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_EPSILON  = 3'd6;
  localparam logic [2:0] REG_FAR_LIM  = 3'd7;

  // Quotient bits produced by the divider, one per cycle.
  localparam int unsigned DIV_STEPS = 32;

  // Divider request: magnitude of the numerator before the Q16 scaling.
  typedef struct packed {
    logic        start;
    logic [32:0] num_mag;
    logic [31:0] den;
  } robb_div_req_t;

  // Divider response: done pulse, quotient overflow and quotient magnitude.
  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] mag;
  } robb_div_rsp_t;

endpackage

### design/robb_divider.sv
// Radix-2 restoring divider for the Q16.16 slab distance quotient.
module robb_divider
  import robb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  robb_div_req_t req_i,
  output robb_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DIV_STEPS + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     den_q, den_d;
  logic            ovf_q, ovf_d;
  logic [32:0]     rem_sh;
  logic            ge;

  // One quotient bit per cycle; the low dividend bits shift out of quo_q
  // while the quotient bits shift in.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    ovf_d  = ovf_q;
    rem_sh = {rem_q, quo_q[31]};
    ge     = rem_sh >= {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {15'b0, req_i.num_mag[32:16]};
      quo_d  = {req_i.num_mag[15:0], 16'b0};
      den_d  = req_i.den;
      // A high part at or above the divisor means a quotient of 2^32 or more.
      ovf_d  = {15'b0, req_i.num_mag[32:16]} >= req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    ovf_q <= ovf_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.mag  = quo_q;

endmodule

### design/ray_obb_slab_intersection_core.sv
// Top level of the ray against oriented box slab test, Q16.16 fixed point.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  one box axis beat, tlast = last axis
//   m_axis    out        m_axis_tvalid / m_axis_tready  entry distance, tuser = hit
//   cfg       in         cfg_we_i (no wait)             register index and write data
//
// An axis beat runs through the sequencer: one 32x32 multiplier forms the six
// projection products, then one radix-2 divider runs 32 iterations for each
// of the two slab distances.
// A near-parallel axis skips the divider, an axis of an already missed box all arithmetic.
// Reset loads the configuration defaults and opens a new box.
// A pending result stalls the next box's last beat in its finish state only.
module ray_obb_slab_intersection_core
  import robb_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Fields from bit 0: axis_x, axis_y, axis_z, box_pos_x, box_pos_y,
  // box_pos_z, slab_min, slab_max.
  input  logic [255:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: entry_distance.
  output logic [31:0]  m_axis_tdata,
  // Fields from bit 0: hit.
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int EffW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [49:0] SatHi = (50'sd1 <<< (EffW - 1)) - 50'sd1;
  localparam logic signed [49:0] SatLo = -SatHi - 50'sd1;

  // Clamp to the signed coordinate range.
  function automatic logic signed [31:0] sat_w(input logic signed [49:0] v);
    logic signed [49:0] r;
    if (v > SatHi) r = SatHi;
    else if (v < SatLo) r = SatLo;
    else r = v;
    return $signed(r[31:0]);
  endfunction

  robb_state_e state_q, state_d;

  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic [30:0]        eps_q;
  logic [30:0]        far_lim_q;

  logic signed [31:0] axis_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] delta_q [3];
  logic signed [31:0] smin_q, smax_q;
  logic               last_q;

  logic signed [63:0] prod_q;
  logic [2:0]         step_q;
  logic signed [49:0] e_acc_q, f_acc_q;
  logic signed [31:0] e_q, f_q;

  logic               sel_q, neg_q;
  logic signed [31:0] t1_q, t2_q;
  logic signed [31:0] near_q, far_q;
  logic               missed_q, box_start_q;

  logic               out_valid_q, out_hit_q;
  logic signed [31:0] out_dist_q;

  logic               in_fire, out_load, div_start;
  logic [1:0]         lane;
  logic signed [31:0] mul_a, mul_b;
  logic signed [49:0] prod_fl;
  logic signed [32:0] num_x;
  logic [31:0]        abs_f;
  logic signed [49:0] q_ext, q_sgn;
  logic signed [31:0] t_res;
  logic signed [31:0] t_lo, t_hi, far_n, near_n;

  robb_div_req_t div_req;
  robb_div_rsp_t div_rsp;

  // Sequencer: next state and handshake strobes.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (!box_start_q && missed_q) ? ST_FINISH : ST_DELTA;
        end
      end
      ST_DELTA:  state_d = ST_MUL;
      ST_MUL:    if (step_q == 3'd6) state_d = ST_REDUCE;
      ST_REDUCE: state_d = ST_CHECK;
      ST_CHECK:  state_d = (abs_f > {1'b0, eps_q}) ? ST_DIV_GO : ST_FINISH;
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) state_d = sel_q ? ST_UPDATE : ST_DIV_GO;
      end
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Multiplier operand selection: three offset projections, then three
  // direction projections.
  always_comb begin
    case (step_q)
      3'd0, 3'd3: lane = 2'd0;
      3'd1, 3'd4: lane = 2'd1;
      3'd2, 3'd5: lane = 2'd2;
      default:    lane = 2'd0;
    endcase
    if (step_q < 3'd3) begin
      mul_a = axis_q[lane];
      mul_b = delta_q[lane];
    end else begin
      mul_a = dir_q[lane];
      mul_b = axis_q[lane];
    end
    // Arithmetic shift floors the product to Q16.16.
    prod_fl = {{2{prod_q[63]}}, prod_q[63:16]};
  end

  // Divider operands: numerator e + slab bound, divisor magnitude |f|.
  always_comb begin
    num_x = sel_q ? ({e_q[31], e_q} + {smax_q[31], smax_q})
                  : ({e_q[31], e_q} + {smin_q[31], smin_q});
    abs_f = f_q[31] ? 32'(-f_q) : 32'(f_q);
    div_req.start   = div_start;
    div_req.num_mag = num_x[32] ? 33'(-num_x) : 33'(num_x);
    div_req.den     = abs_f;
  end

  robb_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Signed, saturated quotient.
  always_comb begin
    q_ext = $signed({18'b0, div_rsp.mag});
    q_sgn = neg_q ? -q_ext : q_ext;
    if (div_rsp.ovf) t_res = neg_q ? $signed(SatLo[31:0]) : $signed(SatHi[31:0]);
    else t_res = sat_w(q_sgn);
  end

  // Interval narrowing.
  always_comb begin
    t_lo   = (t1_q > t2_q) ? t2_q : t1_q;
    t_hi   = (t1_q > t2_q) ? t1_q : t2_q;
    far_n  = (t_hi < far_q) ? t_hi : far_q;
    near_n = (t_lo > near_q) ? t_lo : near_q;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0]  <= '0;
      org_q[1]  <= '0;
      org_q[2]  <= '0;
      dir_q[0]  <= '0;
      dir_q[1]  <= '0;
      dir_q[2]  <= 32'sd65536;
      eps_q     <= 31'd66;
      far_lim_q <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ORIGIN_X: org_q[0]  <= cfg_wdata_i;
        REG_ORIGIN_Y: org_q[1]  <= cfg_wdata_i;
        REG_ORIGIN_Z: org_q[2]  <= cfg_wdata_i;
        REG_DIR_X:    dir_q[0]  <= cfg_wdata_i;
        REG_DIR_Y:    dir_q[1]  <= cfg_wdata_i;
        REG_DIR_Z:    dir_q[2]  <= cfg_wdata_i;
        REG_EPSILON:  eps_q     <= cfg_wdata_i[30:0];
        REG_FAR_LIM:  far_lim_q <= cfg_wdata_i[30:0];
        default:      ;
      endcase
    end
  end

  // Box state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q      <= '0;
      far_q       <= 32'sh7FFF_FFFF;
      missed_q    <= 1'b0;
      box_start_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        box_start_q <= s_axis_tlast;
        if (box_start_q) begin
          near_q   <= '0;
          far_q    <= sat_w($signed({19'b0, far_lim_q}));
          missed_q <= 1'b0;
        end
      end
      if (state_q == ST_CHECK && !(abs_f > {1'b0, eps_q})) begin
        if (smin_q > e_q || smax_q < e_q) missed_q <= 1'b1;
      end
      if (state_q == ST_UPDATE) begin
        far_q  <= far_n;
        near_q <= near_n;
        if (far_n < near_n) missed_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Working registers of the current axis beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      axis_q[0] <= s_axis_tdata[31:0];
      axis_q[1] <= s_axis_tdata[63:32];
      axis_q[2] <= s_axis_tdata[95:64];
      pos_q[0]  <= s_axis_tdata[127:96];
      pos_q[1]  <= s_axis_tdata[159:128];
      pos_q[2]  <= s_axis_tdata[191:160];
      smin_q    <= s_axis_tdata[223:192];
      smax_q    <= s_axis_tdata[255:224];
      last_q    <= s_axis_tlast;
    end
    if (state_q == ST_DELTA) begin
      for (int i = 0; i < 3; i++) begin
        delta_q[i] <= sat_w(50'($signed({pos_q[i][31], pos_q[i]})
                                - $signed({org_q[i][31], org_q[i]})));
      end
      step_q  <= '0;
      e_acc_q <= '0;
      f_acc_q <= '0;
      sel_q   <= 1'b0;
    end
    if (state_q == ST_MUL) begin
      if (step_q != 3'd6) prod_q <= mul_a * mul_b;
      if (step_q >= 3'd1 && step_q <= 3'd3) e_acc_q <= e_acc_q + prod_fl;
      if (step_q >= 3'd4) f_acc_q <= f_acc_q + prod_fl;
      step_q <= step_q + 3'd1;
    end
    if (state_q == ST_REDUCE) begin
      e_q <= sat_w(e_acc_q);
      f_q <= sat_w(f_acc_q);
    end
    if (state_q == ST_DIV_GO) neg_q <= num_x[32] ^ f_q[31];
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      if (sel_q) t2_q <= t_res;
      else t1_q <= t_res;
      sel_q <= 1'b1;
    end
    if (out_load) begin
      out_hit_q  <= !missed_q;
      out_dist_q <= missed_q ? '0 : near_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_dist_q;
  assign m_axis_tuser  = out_hit_q;

`ifndef SYNTHESIS
  // A missed box reports a zero entry distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries a nonzero distance");

  // A live interval is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !missed_q |-> far_q >= near_q)
    else $error("interval empty without miss flag");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV_WAIT)
    else $error("divider result outside its wait state");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the ray against oriented box slab test core.
module tb;
  import robb_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 10;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          PHASE_BEATS   = 86;
  localparam int          PHASES        = 12;
  localparam int          LONG_HOLD     = 3000;
  localparam longint      Q_MAX         = 64'sh7FFF_FFFF;
  localparam longint      Q_MIN         = -64'sh8000_0000;
  localparam logic [31:0] ONE           = 32'h0001_0000;
  localparam logic [31:0] W_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN         = 32'h8000_0000;

  // One box axis beat, first field in the lowest bits.
  typedef struct packed {
    logic [31:0]      slab_max;
    logic [31:0]      slab_min;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] axis;
  } axis_beat_t;

  typedef struct packed {
    logic       last;
    axis_beat_t body;
  } axis_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] entry;
  } box_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [255:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  ray_obb_slab_intersection_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Beats waiting to be sent and box verdicts waiting to come out.
  axis_item_t  axis_q [$];
  box_result_t box_verdicts [$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  tx_idle_pct = 33;
  int  rx_idle_pct = 57;
  bit  in_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  // Shadow of the configuration registers and the running box interval.
  logic [31:0] ray_org [3] = '{32'd0, 32'd0, 32'd0};
  logic [31:0] ray_dir [3] = '{32'd0, 32'd0, ONE};
  logic [30:0] par_eps = 31'd66;
  logic [30:0] far_lim = 31'h7FFF_FFFF;
  longint      span_near = 0;
  longint      span_far = Q_MAX;
  bit          box_missed = 1'b0;
  bit          box_open = 1'b1;

  function automatic longint sat_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Narrow the box interval with one axis and queue the verdict on the last axis.
  function automatic void narrow_slab(axis_item_t it);
    longint      proj_off;
    longint      proj_dir;
    longint      rel;
    longint      ax;
    longint      smin;
    longint      smax;
    longint      t_lo;
    longint      t_hi;
    longint      swap;
    box_result_t res;
    if (box_open) begin
      span_near  = 0;
      span_far   = sat_q(longint'(far_lim));
      box_missed = 1'b0;
    end
    box_open = it.last;
    if (!box_missed) begin
      proj_off = 0;
      proj_dir = 0;
      for (int k = 0; k < 3; k++) begin
        ax  = longint'($signed(it.body.axis[k]));
        rel = sat_q(longint'($signed(it.body.pos[k])) - longint'($signed(ray_org[k])));
        proj_off += (ax * rel) >>> 16;
        proj_dir += (longint'($signed(ray_dir[k])) * ax) >>> 16;
      end
      proj_off = sat_q(proj_off);
      proj_dir = sat_q(proj_dir);
      smin = longint'($signed(it.body.slab_min));
      smax = longint'($signed(it.body.slab_max));
      if ((proj_dir < 0 ? -proj_dir : proj_dir) > longint'(par_eps)) begin
        t_lo = sat_q(((proj_off + smin) * 65536) / proj_dir);
        t_hi = sat_q(((proj_off + smax) * 65536) / proj_dir);
        if (t_lo > t_hi) begin
          swap = t_lo;
          t_lo = t_hi;
          t_hi = swap;
        end
        if (t_hi < span_far) span_far = t_hi;
        if (t_lo > span_near) span_near = t_lo;
        if (span_far < span_near) box_missed = 1'b1;
      end else if (smin - proj_off > 0 || smax - proj_off < 0) begin
        // Near-parallel axis: the origin has to lie inside the slab.
        box_missed = 1'b1;
      end
    end
    if (it.last) begin
      res.hit   = !box_missed;
      res.entry = box_missed ? 32'd0 : span_near[31:0];
      box_verdicts.insert(box_verdicts.size(), res);
    end
  endfunction

  function automatic logic [31:0] rand_span(int unsigned span);
    int v;
    v = int'($urandom_range(2 * span)) - int'(span);
    return v;
  endfunction

  task automatic queue_axis(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] smin, logic [31:0] smax, logic last);
    axis_item_t it;
    it.body.axis     = {az, ay, ax};
    it.body.pos      = {pz, py, px};
    it.body.slab_min = smin;
    it.body.slab_max = smax;
    it.last          = last;
    axis_q.insert(axis_q.size(), it);
  endtask

  // A plausible box: shared position, mostly unit-scale axes, mostly ordered slab bounds.
  task automatic queue_box();
    axis_item_t  it;
    int          n;
    logic [31:0] lo;
    logic [31:0] width;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 3;
    for (int k = 0; k < 3; k++) it.body.pos[k] = rand_span(16 * ONE);
    for (int a = 0; a < n; a++) begin
      case ($urandom_range(19))
        0: it.body.axis = '0;
        1, 2: for (int k = 0; k < 3; k++) it.body.axis[k] = rand_span(3);
        default: for (int k = 0; k < 3; k++) it.body.axis[k] = rand_span(ONE);
      endcase
      lo    = rand_span(4 * ONE);
      width = $urandom_range(8 * ONE);
      if ($urandom_range(9) == 0) begin
        it.body.slab_min = lo + width;
        it.body.slab_max = lo;
      end else begin
        it.body.slab_min = lo;
        it.body.slab_max = lo + width;
      end
      it.last = (a == n - 1);
      axis_q.insert(axis_q.size(), it);
    end
  endtask

  // A beat with every field drawn over its full range.
  task automatic queue_noise();
    axis_item_t it;
    for (int w = 0; w < 8; w++) it.body[32 * w +: 32] = $urandom();
    it.last = ($urandom_range(2) == 0);
    axis_q.insert(axis_q.size(), it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx) inside
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_org[2'(idx - REG_ORIGIN_X)] = val;
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[2'(idx - REG_DIR_X)] = val;
      REG_EPSILON: par_eps = val[30:0];
      default: far_lim = val[30:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Program the ray: typical scene, extremes, fully random, or wide epsilon with a short far limit.
  task automatic program_ray(int kind, bit flip);
    logic [31:0] org [3];
    logic [31:0] dir [3];
    logic [31:0] eps;
    logic [31:0] far;
    for (int k = 0; k < 3; k++) begin
      org[k] = rand_span(8 * ONE);
      dir[k] = rand_span(ONE);
    end
    eps = $urandom_range(2000);
    far = $urandom_range(1) ? W_MAX : 32'($urandom_range(1000 * ONE));
    case (kind)
      1: begin
        for (int k = 0; k < 3; k++) begin
          org[k] = flip ? W_MIN : W_MAX;
          dir[k] = flip ? W_MAX : W_MIN;
        end
        eps = flip ? 32'hFFFF_FFFF : 32'd0;
        far = flip ? 32'd0 : W_MAX;
      end
      2: begin
        for (int k = 0; k < 3; k++) begin
          org[k] = $urandom();
          dir[k] = $urandom();
        end
        eps = $urandom();
        far = $urandom();
      end
      3: begin
        eps = $urandom();
        far = $urandom_range(16 * ONE);
      end
      default: ;
    endcase
    write_reg(REG_ORIGIN_X, org[0]);
    write_reg(REG_ORIGIN_Y, org[1]);
    write_reg(REG_ORIGIN_Z, org[2]);
    write_reg(REG_DIR_X, dir[0]);
    write_reg(REG_DIR_Y, dir[1]);
    write_reg(REG_DIR_Z, dir[2]);
    write_reg(REG_EPSILON, eps);
    write_reg(REG_FAR_LIM, far);
  endtask

  // Wait until every beat is taken and every verdict has come, then let the core settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (axis_q.size() != 0 || s_axis_tvalid || box_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Beat driver on the input stream.
  always @(negedge clk_i) begin : drive_axis
    axis_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (axis_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = axis_q.pop_front();
        s_axis_tdata  <= it.body;
        s_axis_tlast  <= it.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off.
  always @(negedge clk_i) begin : drive_ready
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Accepted input beats feed the predictor.
  always @(posedge clk_i) begin : track_axis
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      narrow_slab(axis_item_t'({s_axis_tlast, s_axis_tdata}));
    end
  end

  // Compare each result beat with the oldest predicted verdict.
  always @(posedge clk_i) begin : check_results
    box_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (box_verdicts.size() == 0) begin
        $display("%0t: unexpected result, hit %0b entry %0d", $time, m_axis_tuser,
                 $signed(m_axis_tdata));
        err_cnt++;
      end else begin
        want = box_verdicts.pop_front();
        if (m_axis_tuser !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit,
                   m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata !== want.entry) begin
          $display("%0t: entry distance mismatch, expected %0d, got %0d", $time,
                   $signed(want.entry), $signed(m_axis_tdata));
          err_cnt++;
        end
      end
    end
  end

  // Run time limit.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: run limit reached, %0d verdicts outstanding", $time,
               box_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Hit through two parallel slabs and one crossing slab, entry at 4.0.
    queue_axis(ONE, 0, 0, 0, 0, 0, -ONE, ONE, 1'b0);
    queue_axis(0, ONE, 0, 0, 0, 0, -ONE, ONE, 1'b0);
    queue_axis(0, 0, ONE, 0, 0, 5 * ONE, -ONE, ONE, 1'b1);
    // Parallel miss with the origin below the slab, then axes of a missed box.
    queue_axis(ONE, 0, 0, 0, 0, 0, ONE, 2 * ONE, 1'b0);
    queue_axis(0, ONE, 0, 0, 0, 0, -ONE, ONE, 1'b0);
    queue_axis(0, 0, ONE, 0, 0, 5 * ONE, -ONE, ONE, 1'b1);
    // Parallel miss with the origin above the slab.
    queue_axis(ONE, 0, 0, 0, 0, 0, -2 * ONE, -ONE, 1'b1);
    // Two disjoint intervals along the ray leave an empty interval.
    queue_axis(0, 0, ONE, 0, 0, 5 * ONE, -ONE, ONE, 1'b0);
    queue_axis(0, 0, ONE, 0, 0, 10 * ONE, -ONE, ONE, 1'b1);
    // Field extremes.
    queue_axis(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0);
    queue_axis(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
    queue_axis(W_MIN, W_MAX, 0, W_MAX, W_MIN, 0, W_MIN, W_MAX, 1'b1);
    // Negative projected direction swaps the crossings.
    queue_axis(0, 0, -ONE, 0, 0, 5 * ONE, -ONE, ONE, 1'b1);
    // Box behind the origin.
    queue_axis(0, 0, ONE, 0, 0, -5 * ONE, -ONE, ONE, 1'b1);
    // Projected direction exactly at epsilon, then just above it.
    queue_axis(0, 0, 32'd66, 0, 0, 0, -ONE, ONE, 1'b1);
    queue_axis(0, 0, 32'd67, 0, 0, 5 * ONE, -ONE, ONE, 1'b1);
    // Quotients that saturate high and low.
    queue_axis(0, 0, 32'd67, 0, 0, W_MAX, W_MAX, W_MAX, 1'b1);
    queue_axis(0, 0, 32'd67, 0, 0, W_MIN, W_MIN, W_MIN, 1'b1);
    wait_idle();

    // Random phases, each under a fresh ray setting; the idle pattern changes every fourth phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      program_ray(phase % 4, ((phase / 4) % 2) == 1);
      case (phase / 4)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (axis_q.size() < PHASE_BEATS) begin
        if ($urandom_range(3) != 0) queue_box();
        else queue_noise();
      end
      // Close any open box so the core is idle at the end of the phase.
      axis_q[axis_q.size() - 1].last = 1'b1;
      if (phase == 8) hold_req = 1'b1;
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### ray_obb_slab_intersection_core.f
design/robb_pkg.sv
design/robb_divider.sv
design/ray_obb_slab_intersection_core.sv
tb/tb.sv
